// ----- sv/sdpfp_pkg.sv -----
// ----------------------------------------------------------------------------
// sdpfp_pkg
// constants, types and helpers for the signed decimal pair frame parser
// ----------------------------------------------------------------------------
package sdpfp_pkg;

   localparam int unsigned BUFFER_BYTES = 17;
   localparam int unsigned IDX_W        = $clog2(BUFFER_BYTES);
   localparam int unsigned POS_W        = $clog2(BUFFER_BYTES + 1);

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned VALUE_W  = 23;
   localparam int unsigned RSP_W    = ((2 * VALUE_W + 7) / 8) * 8;
   localparam int unsigned DIGITS   = 5;
   localparam int unsigned BOOT_LEN = 15;

   localparam int unsigned LEFT_SIGN_AT  = 1;
   localparam int unsigned RIGHT_SIGN_AT = 8;

   localparam logic [BYTE_W-1:0] CH_START = 8'h24;
   localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;

   // sum of digit weights times the ascii zero offset
   localparam logic [23:0] ZERO_BIAS = 24'd533328;

   typedef logic [BYTE_W-1:0] byte_type;

   typedef struct packed {
      logic                          minus;
      logic [DIGITS-1:0][BYTE_W-1:0] digits;
   } field_type;

   function automatic byte_type boot_byte(input int unsigned i);
      byte_type b;
      b = '0;
      unique case (i)
         0:  b = 8'h24;
         1:  b = 8'h2B;
         2:  b = 8'h31;
         3:  b = 8'h32;
         4:  b = 8'h33;
         5:  b = 8'h34;
         6:  b = 8'h35;
         7:  b = 8'h2C;
         8:  b = 8'h2B;
         9:  b = 8'h31;
         10: b = 8'h32;
         11: b = 8'h33;
         12: b = 8'h34;
         13: b = 8'h35;
         14: b = 8'h0A;
         default: b = '0;
      endcase
      return b;
   endfunction

   function automatic logic [VALUE_W-1:0] field_value(input field_type f);
      logic [23:0] acc;
      logic [23:0] val;
      acc = 24'(f.digits[0]) * 24'd10000
          + 24'(f.digits[1]) * 24'd1000
          + 24'(f.digits[2]) * 24'd100
          + 24'(f.digits[3]) * 24'd10
          + 24'(f.digits[4]);
      val = acc - ZERO_BIAS;
      if (f.minus) begin
         val = -val;
      end
      return val[VALUE_W-1:0];
   endfunction

endpackage

// ----- sv/signed_decimal_pair_frame_parser.sv -----
// ----------------------------------------------------------------------------
// signed_decimal_pair_frame_parser
// byte stream frame parser giving two signed five-digit values per frame
// ----------------------------------------------------------------------------
// req channel: one received byte per item in req_tdata.
// rsp channel: one item per newline byte that ends a frame starting with '$',
//   carrying the left and right signed values.
// the frame buffer is held in flip-flops; a '$' byte restarts the write
// position and a full buffer wraps it to entry 0.
// path: a result item appears on rsp after its newline byte is accepted and
//   has passed the snapshot register, then the result register.
// throughput: one byte per cycle while req_tready is high; the buffer write and
//   the two constant-weight digit sums each fit in one register stage.
// reset: buffer holds the boot frame text, write position 0, both stages
//   empty, req_tready high.
// stall: while rsp_tready is low the result register holds; bytes that end
//   no frame keep being accepted, and req_tready drops only when a pending
//   frame snapshot cannot move into the result register.
// ----------------------------------------------------------------------------
module signed_decimal_pair_frame_parser (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [sdpfp_pkg::BYTE_W-1:0]   req_tdata,   // rx_byte
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [sdpfp_pkg::RSP_W-1:0]    rsp_tdata    // left_target, right_target
);
   import sdpfp_pkg::*;

   byte_type                  buf_ff [BUFFER_BYTES];
   byte_type                  buf_in [BUFFER_BYTES];
   logic [POS_W-1:0]          pos_ff;
   logic [POS_W-1:0]          pos_in;
   logic [POS_W-1:0]          wpos;

   logic                      snap_valid_ff;
   logic                      snap_valid_in;
   field_type                 left_ff;
   field_type                 right_ff;
   field_type                 left_in;
   field_type                 right_in;

   logic                      out_valid_ff;
   logic                      out_valid_in;
   logic [VALUE_W-1:0]        left_val_ff;
   logic [VALUE_W-1:0]        right_val_ff;

   logic                      accept;
   logic                      out_free;
   logic                      snap_free;
   logic                      frame_done;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign snap_free  = !snap_valid_ff || out_free;
   assign req_tready = snap_free;
   assign accept     = req_tvalid && req_tready;

   // buffer write
   always_comb begin
      wpos = (req_tdata == CH_START) ? '0 : pos_ff;
      if (wpos >= POS_W'(BUFFER_BYTES)) begin
         wpos = '0;
      end
      pos_in = wpos + POS_W'(1);
      for (int i = 0; i < BUFFER_BYTES; i++) begin
         buf_in[i] = (wpos[IDX_W-1:0] == IDX_W'(i)) ? req_tdata : buf_ff[i];
      end
   end

   assign frame_done = (req_tdata == CH_NL) && (buf_in[0] == CH_START);

   always_comb begin
      left_in.minus  = buf_in[LEFT_SIGN_AT] == CH_MINUS;
      right_in.minus = buf_in[RIGHT_SIGN_AT] == CH_MINUS;
      for (int k = 0; k < DIGITS; k++) begin
         left_in.digits[k]  = buf_in[LEFT_SIGN_AT + 1 + k];
         right_in.digits[k] = buf_in[RIGHT_SIGN_AT + 1 + k];
      end
   end

   always_comb begin
      snap_valid_in = snap_valid_ff && !out_free;
      if (accept && frame_done) begin
         snap_valid_in = 1'b1;
      end
      out_valid_in = out_valid_ff && !rsp_tready;
      if (snap_valid_ff && out_free) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         snap_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         for (int i = 0; i < BUFFER_BYTES; i++) begin
            buf_ff[i] <= boot_byte(i);
         end
      end else begin
         snap_valid_ff <= snap_valid_in;
         out_valid_ff  <= out_valid_in;
         if (accept) begin
            pos_ff <= pos_in;
            for (int i = 0; i < BUFFER_BYTES; i++) begin
               buf_ff[i] <= buf_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && frame_done) begin
         left_ff  <= left_in;
         right_ff <= right_in;
      end
      if (snap_valid_ff && out_free) begin
         left_val_ff  <= field_value(left_ff);
         right_val_ff <= field_value(right_ff);
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_W - 2 * VALUE_W)'(0), right_val_ff, left_val_ff};

endmodule
